>>> hw/rtl/sws_pkg.sv
// Package with the result codes, parse modes, character constants and shared types.
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_ARG_END = 2'd1;
    localparam logic [1:0] KIND_CMD_OK  = 2'd2;
    localparam logic [1:0] KIND_CMD_ERR = 2'd3;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_UNQ    = 3'd1;
    localparam logic [2:0] MODE_UNQ_ESC = 3'd2;
    localparam logic [2:0] MODE_SQ     = 3'd3;
    localparam logic [2:0] MODE_DQ     = 3'd4;
    localparam logic [2:0] MODE_DQ_ESC = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } res_t;

    // Decoded byte: how many results it causes, the results themselves and the next parse mode.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
        logic [2:0] next_mode;
    } dec_t;

endpackage
`default_nettype wire

>>> hw/rtl/sws_decode.sv
// Combinational decoder: parse mode and one byte give the next mode and up to two results.
`timescale 1ns / 1ps
`default_nettype none
module sws_decode (
    input  wire logic [2:0]    mode,
    input  wire logic [7:0]    in_char,
    output sws_pkg::dec_t      dec
);

    logic       is_blank;
    logic       dq_special;
    logic [2:0] m;

    function automatic sws_pkg::res_t mk(input logic [1:0] kind, input logic [7:0] ch);
        sws_pkg::res_t r;
        r.kind = kind;
        r.ch   = (kind == sws_pkg::KIND_CHAR) ? ch : 8'h00;
        r.last = 1'b0;
        return r;
    endfunction

    assign is_blank = (in_char == sws_pkg::CH_SPACE) ||
                      ((in_char >= sws_pkg::CH_TAB) && (in_char <= sws_pkg::CH_CR));
    assign dq_special = (in_char == sws_pkg::CH_BSLASH) || (in_char == sws_pkg::CH_DQUOTE) ||
                        (in_char == sws_pkg::CH_BTICK) || (in_char == sws_pkg::CH_DOLLAR) ||
                        (in_char == sws_pkg::CH_NL);
    // Unused mode codes behave as the between-arguments mode.
    assign m = (mode > sws_pkg::MODE_DQ_ESC) ? sws_pkg::MODE_START : mode;

    always_comb begin
        dec.cnt       = 2'd0;
        dec.r0        = mk(sws_pkg::KIND_CHAR, 8'h00);
        dec.r1        = mk(sws_pkg::KIND_CHAR, 8'h00);
        dec.next_mode = m;
        unique case (m)
            sws_pkg::MODE_UNQ_ESC, sws_pkg::MODE_DQ_ESC: begin
                if (in_char == sws_pkg::CH_NUL) begin
                    dec.cnt       = 2'd1;
                    dec.r0        = mk(sws_pkg::KIND_CMD_ERR, 8'h00);
                    dec.next_mode = sws_pkg::MODE_START;
                end else if (m == sws_pkg::MODE_UNQ_ESC) begin
                    dec.cnt       = 2'd1;
                    dec.r0        = mk(sws_pkg::KIND_CHAR, in_char);
                    dec.next_mode = sws_pkg::MODE_UNQ;
                end else begin
                    dec.next_mode = sws_pkg::MODE_DQ;
                    if (dq_special) begin
                        dec.cnt = 2'd1;
                        dec.r0  = mk(sws_pkg::KIND_CHAR, in_char);
                    end else begin
                        dec.cnt = 2'd2;
                        dec.r0  = mk(sws_pkg::KIND_CHAR, sws_pkg::CH_BSLASH);
                        dec.r1  = mk(sws_pkg::KIND_CHAR, in_char);
                    end
                end
            end
            sws_pkg::MODE_SQ, sws_pkg::MODE_DQ: begin
                if (in_char == sws_pkg::CH_NUL) begin
                    dec.cnt       = 2'd2;
                    dec.r0        = mk(sws_pkg::KIND_ARG_END, 8'h00);
                    dec.r1        = mk(sws_pkg::KIND_CMD_OK, 8'h00);
                    dec.next_mode = sws_pkg::MODE_START;
                end else if (m == sws_pkg::MODE_SQ && in_char == sws_pkg::CH_SQUOTE) begin
                    dec.next_mode = sws_pkg::MODE_UNQ;
                end else if (m == sws_pkg::MODE_DQ && in_char == sws_pkg::CH_DQUOTE) begin
                    dec.next_mode = sws_pkg::MODE_UNQ;
                end else if (m == sws_pkg::MODE_DQ && in_char == sws_pkg::CH_BSLASH) begin
                    dec.next_mode = sws_pkg::MODE_DQ_ESC;
                end else begin
                    dec.cnt = 2'd1;
                    dec.r0  = mk(sws_pkg::KIND_CHAR, in_char);
                end
            end
            default: begin
                if (in_char == sws_pkg::CH_NUL) begin
                    dec.next_mode = sws_pkg::MODE_START;
                    if (m == sws_pkg::MODE_UNQ) begin
                        dec.cnt = 2'd2;
                        dec.r0  = mk(sws_pkg::KIND_ARG_END, 8'h00);
                        dec.r1  = mk(sws_pkg::KIND_CMD_OK, 8'h00);
                    end else begin
                        dec.cnt = 2'd1;
                        dec.r0  = mk(sws_pkg::KIND_CMD_OK, 8'h00);
                    end
                end else if (is_blank) begin
                    dec.next_mode = sws_pkg::MODE_START;
                    if (m == sws_pkg::MODE_UNQ) begin
                        dec.cnt = 2'd1;
                        dec.r0  = mk(sws_pkg::KIND_ARG_END, 8'h00);
                    end
                end else if (in_char == sws_pkg::CH_SQUOTE) begin
                    dec.next_mode = sws_pkg::MODE_SQ;
                end else if (in_char == sws_pkg::CH_DQUOTE) begin
                    dec.next_mode = sws_pkg::MODE_DQ;
                end else if (in_char == sws_pkg::CH_BSLASH) begin
                    dec.next_mode = sws_pkg::MODE_UNQ_ESC;
                end else begin
                    dec.cnt       = 2'd1;
                    dec.r0        = mk(sws_pkg::KIND_CHAR, in_char);
                    dec.next_mode = sws_pkg::MODE_UNQ;
                end
            end
        endcase
        dec.r0.last = (dec.cnt == 2'd1);
        dec.r1.last = 1'b1;
    end

endmodule
`default_nettype wire

>>> hw/rtl/sws_emit.sv
// Result register that holds one decoded byte and hands out its one or two results in order.
`timescale 1ns / 1ps
`default_nettype none
module sws_emit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire sws_pkg::dec_t dec,
    output logic               can_load,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_kind,
    output logic [7:0]         m_out_char,
    output logic               m_last
);

    logic [1:0]    cnt_reg, cnt_next;
    sws_pkg::res_t res0_reg, res0_next;
    sws_pkg::res_t res1_reg, res1_next;
    logic          take;

    assign m_valid    = (cnt_reg != 2'd0);
    assign take       = m_valid && m_ready;
    assign can_load   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign m_kind     = res0_reg.kind;
    assign m_out_char = res0_reg.ch;
    assign m_last     = res0_reg.last;

    always_comb begin
        cnt_next  = cnt_reg;
        res0_next = res0_reg;
        res1_next = res1_reg;
        if (take) begin
            cnt_next  = cnt_reg - 2'd1;
            res0_next = res1_reg;
        end
        // A byte that causes no result only moves the parse mode.
        if (load && (dec.cnt != 2'd0)) begin
            cnt_next  = dec.cnt;
            res0_next = dec.r0;
            res1_next = dec.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("result count out of range");

    a_first_of_two_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !res0_reg.last) else $error("first of two results flagged last");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> res0_reg.last) else $error("final result not flagged last");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && cnt_reg == 2'd2) |=> m_valid) else $error("second result lost");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && dec.cnt != 2'd0) |-> can_load) else $error("result register overwritten");

endmodule
`default_nettype wire

>>> hw/rtl/shell_word_splitter_core.sv
// Top level of the shell word splitter: input register, parse mode register and result stage.
`timescale 1ns / 1ps
`default_nettype none
// Splits a command line, one byte per transaction and byte 0 ending the command, into
// argument characters, argument ends and one command-end result (ok or error) per command.
// A byte is held in an input register, decoded against the parse mode and loaded into the
// result register; a new byte is taken every cycle while results are taken downstream and
// no byte causes two. A byte with two results (an argument end with a command end, or a kept
// backslash inside double quotes) holds the result register until its second result is taken.
// The input register takes one more byte while a result waits downstream.
module shell_word_splitter_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_out_char,
    output logic            m_last
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_char_reg;
    logic [2:0]    mode_reg, mode_next;
    logic          can_load;
    logic          load;
    sws_pkg::dec_t dec;

    assign load    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || can_load;

    sws_decode u_decode (
        .mode    (mode_reg),
        .in_char (in_char_reg),
        .dec     (dec)
    );

    sws_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .dec        (dec),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        mode_next = load ? dec.next_mode : mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= sws_pkg::MODE_START;
        end else begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
        if (s_valid && s_ready) begin
            in_char_reg <= s_in_char;
        end
    end

endmodule
`default_nettype wire
